>>> rtl/core/mts_pkg.sv
// ----------------------------------------------------------------------------
// Min-tracking stack package
// Shared types and constants for the min-tracking stack unit.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 7;

  localparam logic signed [DATA_W-1:0] EMPTY_TOP = -32'sd1;
  localparam logic signed [DATA_W-1:0] EMPTY_MIN = 32'sh7FFF_FFFF;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  typedef struct packed {
    op_e                       kind;
    logic signed [DATA_W-1:0]  push_value;
  } in_item_t;

  typedef struct packed {
    status_e                   status;
    logic signed [DATA_W-1:0]  top_value;
    logic signed [DATA_W-1:0]  min_value;
    logic                      is_empty;
    logic [COUNT_W-1:0]        entry_count;
  } out_item_t;

endpackage

>>> rtl/core/mts_lifo.sv
// ----------------------------------------------------------------------------
// Min-tracking stack LIFO
// One stack with its top entry cached in a register, the entries below it in
// a memory, and the entry just below the top prefetched every cycle.
// ----------------------------------------------------------------------------
module mts_lifo
  import mts_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic                      pop_i,
  input  logic signed [DATA_W-1:0]  data_i,
  output logic [$clog2(DEPTH+1)-1:0] count_o,
  output logic signed [DATA_W-1:0]  top_o,
  output logic [$clog2(DEPTH+1)-1:0] count_next_o,
  output logic signed [DATA_W-1:0]  top_next_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH+1);

  logic signed [DATA_W-1:0] mem [DEPTH];

  logic [CW-1:0]            count_d, count_q;
  logic signed [DATA_W-1:0] top_d, top_q;
  logic signed [DATA_W-1:0] below_q;

  logic                     wr_en;
  logic [CW-1:0]            wr_sub;
  logic [AW-1:0]            wr_addr;
  logic [CW-1:0]            rd_sub;
  logic [AW-1:0]            rd_addr;

  always_comb begin
    count_d = count_q;
    top_d   = top_q;
    wr_en   = 1'b0;
    if (push_i) begin
      count_d = count_q + CW'(1);
      top_d   = data_i;
      wr_en   = (count_q != '0);
    end else if (pop_i) begin
      count_d = count_q - CW'(1);
      top_d   = below_q;
    end
  end

  // Old top moves into the memory at the slot just under the new top.
  assign wr_sub  = count_q - CW'(1);
  assign wr_addr = wr_sub[AW-1:0];
  // Prefetch the entry under the next top.
  assign rd_sub  = count_d - CW'(2);
  assign rd_addr = rd_sub[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= top_q;
    end
    if (wr_en && (wr_addr == rd_addr)) begin
      below_q <= top_q;
    end else begin
      below_q <= mem[rd_addr];
    end
    top_q <= top_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o      = count_q;
  assign top_o        = top_q;
  assign count_next_o = count_d;
  assign top_next_o   = top_d;

endmodule

>>> rtl/core/min_tracking_stack_unit.sv
// ----------------------------------------------------------------------------
// Min-tracking stack unit
// LIFO of signed 32-bit values that reports its running minimum per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_item_i) carries one request:
//   a push of push_value or a pop. Output channel (out_valid_o / out_ready_i
//   / out_item_o) returns exactly one result per request: status, top entry,
//   minimum, empty flag and entry count after the operation.
//   The result is registered and shown in the cycle after acceptance.
//   Throughput: one request per cycle while results are taken. Each request
//   touches only the cached top entries of the value and minimum stacks; the
//   entry under each top is prefetched from its memory every cycle, so
//   back-to-back pops need no wait. An empty stack reports top -1 and
//   minimum 2147483647. Pop of an empty stack reports underflow; push onto
//   a full stack reports overflow and the value is dropped.
//   Reset: both stack counts clear to zero; no memory clearing pass is run,
//   so requests are taken from the first cycle after reset.
//   Stall: when the receiver holds out_ready_i low the result register holds
//   its item and in_ready_o drops until the result is taken.
// ----------------------------------------------------------------------------
module min_tracking_stack_unit
  import mts_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned CW = $clog2(STACK_DEPTH+1);

  logic                     in_fire;
  logic                     is_full;
  logic                     val_push, val_pop;
  logic                     min_push, min_pop;
  logic                     min_le;

  logic [CW-1:0]            val_cnt, val_cnt_next;
  logic signed [DATA_W-1:0] val_top, val_top_next;
  logic [CW-1:0]            min_cnt, min_cnt_next;
  logic signed [DATA_W-1:0] min_top, min_top_next;

  status_e                  status;
  out_item_t                out_item_d, out_item_q;
  logic                     out_valid_q;

  // Take a new request whenever the result register is free or being drained.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign is_full = (val_cnt == CW'(STACK_DEPTH));
  assign min_le  = (min_cnt == '0) || (in_item_i.push_value <= min_top);

  // Decide the stack moves for this request.
  always_comb begin
    val_push = 1'b0;
    val_pop  = 1'b0;
    min_push = 1'b0;
    min_pop  = 1'b0;
    status   = ST_OK;
    if (in_fire) begin
      if (in_item_i.kind == OP_PUSH) begin
        if (is_full) begin
          status = ST_OVERFLOW;
        end else begin
          val_push = 1'b1;
          // Track a new minimum, ties included, so duplicates pop correctly.
          min_push = min_le && (min_cnt != CW'(STACK_DEPTH));
        end
      end else begin
        if (val_cnt == '0) begin
          status = ST_UNDERFLOW;
        end else begin
          val_pop = 1'b1;
          // Drop the minimum only when the departing top is that minimum.
          min_pop = (min_cnt != '0) && (val_top == min_top);
        end
      end
    end
  end

  mts_lifo #(
    .DEPTH (STACK_DEPTH)
  ) u_val_lifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (val_push),
    .pop_i        (val_pop),
    .data_i       (in_item_i.push_value),
    .count_o      (val_cnt),
    .top_o        (val_top),
    .count_next_o (val_cnt_next),
    .top_next_o   (val_top_next)
  );

  mts_lifo #(
    .DEPTH (STACK_DEPTH)
  ) u_min_lifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (min_push),
    .pop_i        (min_pop),
    .data_i       (in_item_i.push_value),
    .count_o      (min_cnt),
    .top_o        (min_top),
    .count_next_o (min_cnt_next),
    .top_next_o   (min_top_next)
  );

  // Build the result from the post-operation state.
  always_comb begin
    out_item_d.status      = status;
    out_item_d.top_value   = (val_cnt_next == '0) ? EMPTY_TOP : val_top_next;
    out_item_d.min_value   = (min_cnt_next == '0) ? EMPTY_MIN : min_top_next;
    out_item_d.is_empty    = (val_cnt_next == '0);
    out_item_d.entry_count = COUNT_W'(val_cnt_next);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

>>> rtl/core/mts_checker.sv
// ----------------------------------------------------------------------------
// Min-tracking stack checker
// Port-level assertions for the min-tracking stack unit, bound to its top.
// ----------------------------------------------------------------------------
module mts_checker
  import mts_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_o,
  input  in_item_t  in_item_i,
  input  logic      out_valid_o,
  input  logic      out_ready_i,
  input  out_item_t out_item_o
);

  // Hold a stalled result until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result dropped or changed while stalled");

  // Every accepted request yields a result on the next cycle.
  a_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("no result one cycle after request");

  // Back-pressure only while a result is waiting.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a waiting result");

  // An empty stack reports the empty markers.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.is_empty |->
      out_item_o.entry_count == '0 && out_item_o.top_value == EMPTY_TOP &&
      out_item_o.min_value == EMPTY_MIN)
    else $error("empty result with non-empty fields");

  // Underflow leaves the stack empty.
  a_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == ST_UNDERFLOW |-> out_item_o.is_empty)
    else $error("underflow on a non-empty stack");

endmodule

bind min_tracking_stack_unit mts_checker u_mts_checker (.*);

>>> bench/min_tracking_stack_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Min-tracking stack unit testbench
// Drives push and pop requests through the valid/ready input channel and
// checks every returned result, field by field, against a stack and minimum
// tracker kept inside the bench. Random sender gaps and receiver stalls cover
// the handshake; directed requests cover the empty, extreme-value, repeated-
// minimum and full-stack cases.
// ----------------------------------------------------------------------------
module min_tracking_stack_unit_test;
  import mts_pkg::*;

  localparam int STACK_DEPTH = 64;
  localparam int IDLE_LIMIT  = 2000;   // cycles with no handshake before giving up
  localparam int PRINT_CAP   = 50;     // keep the log short on a broken build

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  min_tracking_stack_unit #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  // Bench copy of the stack: values, running minimums and their depths.
  logic signed [DATA_W-1:0] model_values [STACK_DEPTH];
  logic signed [DATA_W-1:0] model_mins   [STACK_DEPTH];
  int                       model_depth;
  int                       model_min_depth;

  // Results still owed by the unit, oldest first.
  out_item_t expected_results[$];

  int error_count;
  int results_checked;
  int push_count;
  int pop_count;
  int overflow_count;
  int underflow_count;
  int peak_depth;

  // Upper bounds of the per-request random waits on each side.
  int sender_gap_max;
  int receiver_stall_max;

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Stack tracker: apply one request and return the result it must produce.
  // --------------------------------------------------------------------------
  function automatic out_item_t apply_request(in_item_t req);
    out_item_t res;
    res = '0;
    res.status = ST_OK;
    if (req.kind == OP_PUSH) begin
      push_count++;
      if (model_depth >= STACK_DEPTH) begin
        // Full: drop the value, nothing moves.
        res.status = ST_OVERFLOW;
        overflow_count++;
      end else begin
        model_values[model_depth] = req.push_value;
        model_depth++;
        // Ties go on the minimum stack too, so a later pop of one copy
        // leaves the other copy as the minimum.
        if (model_min_depth == 0 || req.push_value <= model_mins[model_min_depth-1]) begin
          model_mins[model_min_depth] = req.push_value;
          model_min_depth++;
        end
      end
    end else begin
      pop_count++;
      if (model_depth == 0) begin
        res.status = ST_UNDERFLOW;
        underflow_count++;
      end else begin
        if (model_min_depth > 0 &&
            model_values[model_depth-1] == model_mins[model_min_depth-1]) begin
          model_min_depth--;
        end
        model_depth--;
      end
    end
    if (model_depth > peak_depth) peak_depth = model_depth;
    res.top_value   = (model_depth == 0) ? EMPTY_TOP : model_values[model_depth-1];
    res.min_value   = (model_min_depth == 0) ? EMPTY_MIN : model_mins[model_min_depth-1];
    res.is_empty    = (model_depth == 0);
    res.entry_count = COUNT_W'(model_depth);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Mismatch reporting
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    if (error_count < PRINT_CAP) $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic compare_result(out_item_t got, out_item_t want);
    if (got.status !== want.status)
      report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
    if (got.top_value !== want.top_value)
      report_mismatch($sformatf("top got %0d want %0d", got.top_value, want.top_value));
    if (got.min_value !== want.min_value)
      report_mismatch($sformatf("min got %0d want %0d", got.min_value, want.min_value));
    if (got.is_empty !== want.is_empty)
      report_mismatch($sformatf("empty got %0b want %0b", got.is_empty, want.is_empty));
    if (got.entry_count !== want.entry_count)
      report_mismatch($sformatf("count got %0d want %0d", got.entry_count, want.entry_count));
  endtask

  // --------------------------------------------------------------------------
  // Result checker and request monitor. Sample at the rising edge: check the
  // result taken on this edge first, then queue the expectation for the
  // request taken on this edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request pending");
        end else begin
          compare_result(out_item, expected_results.pop_front());
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_request(in_item));
      end
    end
  end

  // Watchdog: give up when neither channel moves for too long.
  int idle_cycles;
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall a random number of cycles before each result, then hold
  // ready high until one is taken.
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    wait (rst_ni);
    forever begin
      stall = $urandom_range(0, receiver_stall_max);
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  // --------------------------------------------------------------------------
  // Sender. Enter and leave at a falling edge, so the tracker has already
  // taken the previous request when the caller picks the next value. With no
  // gap drawn, valid stays high straight into the next request.
  // --------------------------------------------------------------------------
  task automatic send_request(op_e kind, logic signed [DATA_W-1:0] value);
    int gap;
    gap = $urandom_range(0, sender_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid        <= 1'b1;
    in_item.kind       <= kind;
    in_item.push_value <= value;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  task automatic push_item(logic signed [DATA_W-1:0] value);
    send_request(OP_PUSH, value);
  endtask

  // Pops carry random payload bits; the unit must ignore them.
  task automatic pop_item();
    send_request(OP_POP, $urandom);
  endtask

  task automatic set_idling(int gap_max, int stall_max);
    sender_gap_max     = gap_max;
    receiver_stall_max = stall_max;
  endtask

  // Mix of value shapes: full range, small clustered values, extremes, values
  // next to the current minimum and copies of the current top.
  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom;
      3, 4: begin
        v = $urandom_range(0, 8);
        v = v - 4;
      end
      5: begin
        case ($urandom_range(0, 5))
          0: v = 32'sh8000_0000;
          1: v = 32'sh8000_0001;
          2: v = 32'sh7FFF_FFFF;
          3: v = 32'sh7FFF_FFFE;
          4: v = -32'sd1;
          default: v = '0;
        endcase
      end
      6, 7: begin
        if (model_min_depth > 0) begin
          v = $urandom_range(0, 2);
          v = model_mins[model_min_depth-1] + v - 1;
        end else begin
          v = $urandom;
        end
      end
      default: v = (model_depth > 0) ? model_values[model_depth-1] : $urandom;
    endcase
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Pops of an empty stack underflow and report the empty view; a pushed -1
  // looks like the empty top but must not read as empty.
  task automatic test_empty_stack();
    set_idling(0, 0);
    pop_item();
    push_item(-32'sd1);
    pop_item();
    pop_item();
  endtask

  // Both ends of the signed range, with a repeated most-negative value.
  task automatic test_extreme_values();
    set_idling(3, 3);
    push_item(32'sh7FFF_FFFF);
    push_item(32'sh8000_0000);
    push_item(32'sh8000_0000);
    push_item('0);
    repeat (4) pop_item();
  endtask

  // Repeated minimum: each copy goes on the minimum stack, so popping one
  // copy keeps the minimum; a larger value never disturbs it.
  task automatic test_repeated_minimum();
    set_idling(10, 10);
    push_item(32'sd5);
    push_item(32'sd3);
    push_item(32'sd3);
    push_item(32'sd7);
    push_item(32'sd3);
    repeat (5) pop_item();
  endtask

  // Fill to full, push past it, then drain and pop past empty.
  task automatic test_fill_and_overflow(int rounds);
    for (int r = 0; r < rounds; r++) begin
      case (r % 3)
        0: set_idling(0, 0);
        1: set_idling(10, 10);
        default: set_idling(0, 10);
      endcase
      while (model_depth < STACK_DEPTH) push_item(pick_value());
      repeat ($urandom_range(1, 4)) push_item(pick_value());
      while (model_depth > 0) pop_item();
      repeat ($urandom_range(1, 2)) pop_item();
    end
  endtask

  // Segments of random pushes and pops, each with its own push bias and
  // idling pattern, so the depth wanders over the whole range.
  task automatic test_random_mix(int segments, int per_segment);
    int push_pct;
    for (int s = 0; s < segments; s++) begin
      case ($urandom_range(0, 3))
        0: set_idling(0, 0);
        1: set_idling(10, 0);
        2: set_idling(0, 10);
        default: set_idling(10, 10);
      endcase
      case ($urandom_range(0, 3))
        0: push_pct = 30;
        1: push_pct = 50;
        2: push_pct = 60;
        default: push_pct = 75;
      endcase
      repeat (per_segment) begin
        if ($urandom_range(1, 100) <= push_pct) push_item(pick_value());
        else pop_item();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    out_ready = 1'b0;
    set_idling(0, 0);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_stack();
    test_extreme_values();
    test_repeated_minimum();
    test_fill_and_overflow(3);
    test_random_mix(10, 100);

    // Drop valid, drain outstanding results, then let a few cycles pass to
    // catch any stray result.
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d pushes and %0d pops, with %0d overflows and %0d underflows",
             push_count, pop_count, overflow_count, underflow_count);
    $display("Checked %0d results; deepest stack %0d of %0d entries",
             results_checked, peak_depth, STACK_DEPTH);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
